@@ rtl/core/oec_pkg.sv @@
// Shared types and constants for the occupancy exhaust controller.
// Holds the transfer payload structs, config reset values and mode codes.
// No dependencies.
package oec_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int CFG_INDEX_W = 3;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_VISIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_ON         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_ONE      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_TWO      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_PRESENT = 3'd6;

  // Config reset values
  localparam logic [15:0] DISTANCE_LIMIT_RST = 16'd445;
  localparam logic [15:0] SIGNAL_LIMIT_RST   = 16'd500;
  localparam logic [15:0] SHORT_VISIT_RST    = 16'd15000;
  localparam logic [15:0] RUN_ON_RST         = 16'd30000;
  localparam logic [15:0] TOUCH_LIMIT_RST    = 16'hFFFF;
  localparam logic [1:0]  SENSOR_PRESENT_RST = 2'b00;

  // Exhaust mode codes
  localparam logic [1:0] MODE_OFF_FREE = 2'd0;
  localparam logic [1:0] MODE_OFF_OCC  = 2'd1;
  localparam logic [1:0] MODE_ON_FREE  = 2'd2;
  localparam logic [1:0] MODE_ON_OCC   = 2'd3;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] dist_one_mm;
    logic [15:0] signal_one;
    logic [7:0]  status_one;
    logic [15:0] dist_two_mm;
    logic [15:0] signal_two;
    logic [7:0]  status_two;
    logic [15:0] touch_one;
    logic [15:0] touch_two;
    logic [15:0] elapsed_ms;
  } oec_in_t;

  typedef struct packed {
    logic       exhaust_on;
    logic       flush_one;
    logic       flush_two;
    logic       occupied_one;
    logic       occupied_two;
    logic       fault_one;
    logic       fault_two;
    logic [1:0] mode;
  } oec_out_t;

  typedef struct packed {
    logic [15:0] distance_limit_mm;
    logic [15:0] signal_limit;
    logic [15:0] short_visit_ms;
    logic [15:0] run_on_ms;
    logic [15:0] touch_one_limit;
    logic [15:0] touch_two_limit;
    logic [1:0]  sensor_present;
  } oec_cfg_t;

  // Classified sample handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  present;
    logic        occ_one;
    logic        occ_two;
    logic        good_one;
    logic        good_two;
    logic        flush_one;
    logic        flush_two;
    logic [15:0] elapsed_ms;
  } oec_cls_t;

endpackage

@@ rtl/core/occupancy_exhaust_controller_unit.sv @@
// Occupancy exhaust controller, top level: config registers and the pipeline.
// Depends on oec_pkg, oec_front, oec_queue, oec_back.
// A transferred sample is written into the queue, then popped into the back end's result register.
// Throughput: one sample per cycle while out_ready holds; the back end's state update sets it.
// Reset (rst, synchronous, active high) restores config defaults, clears mode,
// timer and occupancy, fills the history with good bits, and empties the queue and result register.
module occupancy_exhaust_controller_unit #(
  parameter int HISTORY_DEPTH = oec_pkg::HISTORY_DEPTH_DEFAULT,
  parameter int QUEUE_DEPTH   = oec_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  oec_pkg::oec_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output oec_pkg::oec_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [oec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import oec_pkg::*;

  oec_cfg_t cfg;
  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  oec_cls_t q_push_item;
  oec_cls_t q_head;

  // Config writes always complete in one transfer; indexes past the list drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.distance_limit_mm <= DISTANCE_LIMIT_RST;
      cfg.signal_limit      <= SIGNAL_LIMIT_RST;
      cfg.short_visit_ms    <= SHORT_VISIT_RST;
      cfg.run_on_ms         <= RUN_ON_RST;
      cfg.touch_one_limit   <= TOUCH_LIMIT_RST;
      cfg.touch_two_limit   <= TOUCH_LIMIT_RST;
      cfg.sensor_present    <= SENSOR_PRESENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISTANCE_LIMIT: cfg.distance_limit_mm <= cfg_data;
        REG_SIGNAL_LIMIT:   cfg.signal_limit      <= cfg_data;
        REG_SHORT_VISIT:    cfg.short_visit_ms    <= cfg_data;
        REG_RUN_ON:         cfg.run_on_ms         <= cfg_data;
        REG_TOUCH_ONE:      cfg.touch_one_limit   <= cfg_data;
        REG_TOUCH_TWO:      cfg.touch_two_limit   <= cfg_data;
        REG_SENSOR_PRESENT: cfg.sensor_present    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each sample as it is transferred in
  oec_front u_front (
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // Queue decouples intake from the state update
  oec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back end: advance timer, history and mode; hold the result until taken
  oec_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  // Exhaust drive is the high bit of the reported mode
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.exhaust_on == out_item.mode[1]))
    else $error("exhaust drive disagrees with mode");

  // The off-occupied mode is never entered from reset
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.mode != MODE_OFF_OCC))
    else $error("unreachable mode reported");

  // A fault is only ever reported for a present sensor
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.fault_one || out_item.fault_two)) |->
      ((!out_item.fault_one || cfg.sensor_present[0]) &&
       (!out_item.fault_two || cfg.sensor_present[1])))
    else $error("fault on absent sensor");

  // Intake stalls only while the queue holds no free slot
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("intake stalled with queue empty");
`endif

endmodule

@@ rtl/core/oec_front.sv @@
// Front end: accepts samples and classifies them against the config limits.
// Depends on oec_pkg.
module oec_front (
  input  oec_pkg::oec_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  oec_pkg::oec_in_t  in_item,
  input  logic              q_full,
  output logic              q_push,
  output oec_pkg::oec_cls_t q_item
);
  import oec_pkg::*;

  // Status codes 0 and 2 count as good
  function automatic logic status_good(input logic [7:0] status);
    return (status[7:2] == 6'd0) && !status[0];
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.present    = cfg.sensor_present;
    q_item.occ_one    = (in_item.dist_one_mm < cfg.distance_limit_mm) &&
                        (in_item.signal_one > cfg.signal_limit);
    q_item.occ_two    = (in_item.dist_two_mm < cfg.distance_limit_mm) &&
                        (in_item.signal_two > cfg.signal_limit);
    q_item.good_one   = status_good(in_item.status_one);
    q_item.good_two   = status_good(in_item.status_two);
    q_item.flush_one  = in_item.touch_one > cfg.touch_one_limit;
    q_item.flush_two  = in_item.touch_two > cfg.touch_two_limit;
    q_item.elapsed_ms = in_item.elapsed_ms;
  end

endmodule

@@ rtl/core/oec_queue.sv @@
// Short queue between front and back ends, flop-based.
// Depends on oec_pkg.
module oec_queue #(
  parameter int DEPTH = oec_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  oec_pkg::oec_cls_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output oec_pkg::oec_cls_t head
);
  import oec_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_PTR = ADDR_W'(DEPTH - 1);

  oec_cls_t          slots [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == DEPTH_CNT);
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/oec_back.sv @@
// Back end: dwell timer, status history, exhaust mode machine, result register.
// Depends on oec_pkg.
module oec_back #(
  parameter int HISTORY_DEPTH = oec_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  oec_pkg::oec_cfg_t cfg,
  input  logic              q_valid,
  input  oec_pkg::oec_cls_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output oec_pkg::oec_out_t out_item
);
  import oec_pkg::*;

  logic [1:0]               mode;
  logic [1:0]               mode_next;
  logic [15:0]              dwell_timer;
  logic [15:0]              dwell_timer_next;
  logic [16:0]              timer_sum;
  logic [15:0]              timer_sat;
  logic                     occupied_one;
  logic                     occupied_two;
  logic                     occ_one_now;
  logic                     occ_two_now;
  logic                     any_occ;
  logic                     fault_one;
  logic                     fault_two;
  logic [HISTORY_DEPTH-1:0] good_one_hist;
  logic [HISTORY_DEPTH-1:0] good_two_hist;
  logic [HISTORY_DEPTH-1:0] good_one_hist_next;
  logic [HISTORY_DEPTH-1:0] good_two_hist_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // Saturating timer
  assign timer_sum = {1'b0, dwell_timer} + {1'b0, q_item.elapsed_ms};
  assign timer_sat = timer_sum[16] ? TIMER_MAX : timer_sum[15:0];

  assign occ_one_now = q_item.present[0] ? q_item.occ_one : occupied_one;
  assign occ_two_now = q_item.present[1] ? q_item.occ_two : occupied_two;
  assign any_occ     = occ_one_now || occ_two_now;

  // History keeps one good bit per entry; fault when none is good
  assign fault_one = q_item.present[0] && !(|good_one_hist);
  assign fault_two = q_item.present[1] && !(|good_two_hist);

  always_comb begin
    good_one_hist_next    = good_one_hist;
    good_two_hist_next    = good_two_hist;
    if (q_item.present[0]) begin
      good_one_hist_next[0] = q_item.good_one;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        good_one_hist_next[i] = good_one_hist[i-1];
      end
    end
    if (q_item.present[1]) begin
      good_two_hist_next[0] = q_item.good_two;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        good_two_hist_next[i] = good_two_hist[i-1];
      end
    end
  end

  always_comb begin
    mode_next        = mode;
    dwell_timer_next = timer_sat;
    unique case (mode)
      MODE_OFF_FREE: begin
        if (any_occ) begin
          mode_next        = MODE_ON_OCC;
          dwell_timer_next = '0;
        end
      end
      MODE_OFF_OCC: begin
        mode_next        = MODE_ON_OCC;
        dwell_timer_next = '0;
      end
      MODE_ON_OCC: begin
        if (!any_occ) begin
          if (timer_sat < cfg.short_visit_ms) begin
            mode_next = MODE_OFF_FREE;
          end else begin
            mode_next        = MODE_ON_FREE;
            dwell_timer_next = '0;
          end
        end
      end
      MODE_ON_FREE: begin
        // Run-on timeout overrides a return to occupied
        if (timer_sat > cfg.run_on_ms) begin
          mode_next = MODE_OFF_FREE;
        end else if (any_occ) begin
          mode_next = MODE_ON_OCC;
        end
      end
      default: mode_next = MODE_OFF_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OFF_FREE;
      dwell_timer   <= '0;
      occupied_one  <= 1'b0;
      occupied_two  <= 1'b0;
      good_one_hist <= '1;
      good_two_hist <= '1;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        mode          <= mode_next;
        dwell_timer   <= dwell_timer_next;
        occupied_one  <= occ_one_now;
        occupied_two  <= occ_two_now;
        good_one_hist <= good_one_hist_next;
        good_two_hist <= good_two_hist_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item.exhaust_on   <= mode_next[1];
      out_item.flush_one    <= q_item.flush_one;
      out_item.flush_two    <= q_item.flush_two;
      out_item.occupied_one <= occ_one_now;
      out_item.occupied_two <= occ_two_now;
      out_item.fault_one    <= fault_one;
      out_item.fault_two    <= fault_two;
      out_item.mode         <= mode_next;
    end
  end

endmodule
